/* rtl/idu_pkg.sv */
// Shared constants, types and helper functions of the integer matrix determinant unit.
package idu_pkg;

    localparam int MAX_SIZE = 4;
    localparam int CELLS    = MAX_SIZE * MAX_SIZE;
    localparam int RW       = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SW       = $clog2(MAX_SIZE + 1);
    localparam int AW       = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int DW       = 32;
    localparam int CFG_W    = 3;

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(3);

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } t_alu_op;

    typedef struct packed {
        t_alu_op              op;
        logic signed [DW-1:0] a;
        logic signed [DW-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic signed [DW-1:0] res;
        logic                 ov;
    } t_alu_rsp;

    typedef struct packed {
        logic          found;
        logic [RW-1:0] idx;
    } t_pick;

    typedef enum logic [3:0] {
        S_LOAD,
        S_ENTER,
        S_B_RD0,
        S_B_RD1,
        S_B_MUL0,
        S_B_RD3,
        S_B_MUL1,
        S_B_SUB,
        S_E_RD,
        S_E_SIGN,
        S_RET_MUL,
        S_RET_ADD,
        S_RET_NEXT,
        S_POP
    } t_state;

    function automatic t_pick pick_row(input logic [MAX_SIZE-1:0] mask,
                                       input logic [SW-1:0] start);
        t_pick p;
        p.found = 1'b0;
        p.idx   = '0;
        for (int i = MAX_SIZE - 1; i >= 0; i--) begin
            if (mask[i] && (i >= int'(start))) begin
                p.found = 1'b1;
                p.idx   = RW'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                input logic [SW-1:0] col);
        return AW'(int'(row) * MAX_SIZE + int'(col));
    endfunction

endpackage

/* rtl/idu_if.sv */
// Stream interfaces for matrix element beats and determinant result beats.
interface idu_elem_if;
    logic                            valid;
    logic                            ready;
    logic signed [idu_pkg::DW-1:0]   element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface idu_det_if;
    logic                            valid;
    logic                            ready;
    logic signed [idu_pkg::DW-1:0]   det_value;
    logic                            overflow;

    modport source (output valid, output det_value, output overflow, input ready);
    modport sink   (input valid, input det_value, input overflow, output ready);
endinterface

/* rtl/idu_alu.sv */
// Shared add, subtract and multiply unit with signed 32-bit range check.
module idu_alu (
    input  idu_pkg::t_alu_req i_req,
    output idu_pkg::t_alu_rsp o_rsp
);
    logic signed [63:0] wide;

    always_comb begin
        unique case (i_req.op)
            idu_pkg::ALU_ADD: wide = 64'(i_req.a) + 64'(i_req.b);
            idu_pkg::ALU_SUB: wide = 64'(i_req.a) - 64'(i_req.b);
            idu_pkg::ALU_MUL: wide = 64'(i_req.a) * 64'(i_req.b);
            default:          wide = '0;
        endcase
    end

    assign o_rsp.res = wide[idu_pkg::DW-1:0];
    assign o_rsp.ov  = (wide[63:idu_pkg::DW-1] != {(65 - idu_pkg::DW){wide[idu_pkg::DW-1]}});
endmodule

/* rtl/idu_store.sv */
// Matrix element memory with one write port and one registered read port.
module idu_store (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [idu_pkg::AW-1:0]        i_waddr,
    input  logic signed [idu_pkg::DW-1:0] i_wdata,
    input  logic [idu_pkg::AW-1:0]        i_raddr,
    output logic signed [idu_pkg::DW-1:0] o_rdata
);
    logic signed [idu_pkg::DW-1:0] r_mem [0:idu_pkg::CELLS-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/integer_matrix_determinant_unit.sv */
// Determinant unit top level: element loader, cofactor expansion sequencer and result register.
// Elements arrive one beat per cycle in row-major order; after the last element the unit
// walks the cofactor expansion along the first column on one shared 32-bit multiply/add
// unit, reading the element memory one word at a time. An n x n matrix takes n*n element
// beats; for size 1 the result beat is registered straight from the last element's beat,
// and for larger sizes it is registered when the expansion finishes; the element port is
// not ready during the expansion, and while a result beat waits to be taken it still takes
// elements but holds off the last element of the next matrix. Wrapped 32-bit arithmetic is
// used throughout, and the overflow bit is set if any product or sum left the signed
// 32-bit range.
module integer_matrix_determinant_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    idu_elem_if.sink              i_elem,
    idu_det_if.source             o_det,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [2:0]            i_paddr,
    input  logic [31:0]           i_pwdata,
    output logic [31:0]           o_prdata,
    output logic                  o_pready
);
    localparam int MS = idu_pkg::MAX_SIZE;
    localparam int RW = idu_pkg::RW;
    localparam int SW = idu_pkg::SW;
    localparam int DW = idu_pkg::DW;

    idu_pkg::t_state r_state, n_state;

    logic [idu_pkg::CFG_W-1:0] r_cfg;
    logic [RW-1:0]             r_lrow, n_lrow, r_lcol, n_lcol;
    logic [SW-1:0]             r_lvl, n_lvl;
    logic [MS-1:0]             r_mask [0:MS];
    logic [MS-1:0]             n_mask [0:MS];
    logic [RW-1:0]             r_row  [0:MS];
    logic [RW-1:0]             n_row  [0:MS];
    logic                      r_sign [0:MS];
    logic                      n_sign [0:MS];
    logic signed [DW-1:0]      r_acc  [0:MS];
    logic signed [DW-1:0]      n_acc  [0:MS];
    logic signed [DW-1:0]      r_t    [0:MS];
    logic signed [DW-1:0]      n_t    [0:MS];
    logic signed [DW-1:0]      r_opa, n_opa, r_p0, n_p0, r_ret, n_ret;
    logic                      r_ov, n_ov;
    logic                      r_out_valid, n_out_valid;
    logic signed [DW-1:0]      r_det, n_det;
    logic                      r_det_ov, n_det_ov;

    logic [SW-1:0]             size_use;
    logic [SW-1:0]             col;
    logic                      cfg_wr;
    logic                      elem_acc;
    logic                      last_elem;
    idu_pkg::t_pick            bp0, bp1, nxt;
    idu_pkg::t_alu_req         alu_req;
    idu_pkg::t_alu_rsp         alu_rsp;
    logic [idu_pkg::AW-1:0]    rd_addr;
    logic signed [DW-1:0]      rdata;
    logic [MS-1:0]             full_mask;

    always_comb begin
        if (r_cfg == '0) begin
            size_use = SW'(1);
        end else if (int'(r_cfg) > MS) begin
            size_use = SW'(MS);
        end else begin
            size_use = SW'(r_cfg);
        end
    end

    always_comb begin
        for (int i = 0; i < MS; i++) begin
            full_mask[i] = (i < int'(size_use));
        end
    end

    assign cfg_wr    = i_psel && i_penable && i_pwrite && (i_paddr[2] == 1'b0);
    assign o_pready  = 1'b1;
    assign o_prdata  = (i_paddr[2] == 1'b0) ? 32'(r_cfg) : 32'd0;

    assign i_elem.ready = (r_state == idu_pkg::S_LOAD) && !(r_out_valid && last_elem);
    assign elem_acc     = i_elem.valid && i_elem.ready;
    assign last_elem    = (SW'(r_lrow) == size_use - SW'(1)) &&
                          (SW'(r_lcol) == size_use - SW'(1));

    assign o_det.valid     = r_out_valid;
    assign o_det.det_value = r_det;
    assign o_det.overflow  = r_det_ov;

    assign col = size_use - r_lvl;
    assign bp0 = idu_pkg::pick_row(r_mask[r_lvl], '0);
    assign bp1 = idu_pkg::pick_row(r_mask[r_lvl], SW'(bp0.idx) + SW'(1));
    assign nxt = idu_pkg::pick_row(r_mask[r_lvl], SW'(r_row[r_lvl]) + SW'(1));

    always_comb begin
        unique case (r_state)
            idu_pkg::S_B_RD0:  rd_addr = idu_pkg::cell_addr(bp0.idx, col);
            idu_pkg::S_B_RD1:  rd_addr = idu_pkg::cell_addr(bp1.idx, col + SW'(1));
            idu_pkg::S_B_MUL0: rd_addr = idu_pkg::cell_addr(bp1.idx, col);
            idu_pkg::S_B_RD3:  rd_addr = idu_pkg::cell_addr(bp0.idx, col + SW'(1));
            idu_pkg::S_E_RD:   rd_addr = idu_pkg::cell_addr(r_row[r_lvl], col);
            default:           rd_addr = '0;
        endcase
    end

    idu_store u_store (
        .i_clk   (i_clk),
        .i_we    (elem_acc),
        .i_waddr (idu_pkg::cell_addr(r_lrow, SW'(r_lcol))),
        .i_wdata (i_elem.element_value),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    idu_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_lrow      = r_lrow;
        n_lcol      = r_lcol;
        n_lvl       = r_lvl;
        n_mask      = r_mask;
        n_row       = r_row;
        n_sign      = r_sign;
        n_acc       = r_acc;
        n_t         = r_t;
        n_opa       = r_opa;
        n_p0        = r_p0;
        n_ret       = r_ret;
        n_ov        = r_ov;
        n_out_valid = r_out_valid;
        n_det       = r_det;
        n_det_ov    = r_det_ov;
        alu_req.op  = idu_pkg::ALU_ADD;
        alu_req.a   = '0;
        alu_req.b   = '0;

        if (o_det.valid && o_det.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            idu_pkg::S_LOAD: begin
                if (elem_acc) begin
                    if (last_elem) begin
                        n_lrow = '0;
                        n_lcol = '0;
                        if (size_use == SW'(1)) begin
                            n_det       = i_elem.element_value;
                            n_det_ov    = 1'b0;
                            n_out_valid = 1'b1;
                        end else begin
                            n_lvl           = size_use;
                            n_mask[size_use] = full_mask;
                            n_ov            = 1'b0;
                            n_state         = idu_pkg::S_ENTER;
                        end
                    end else if (SW'(r_lcol) == size_use - SW'(1)) begin
                        n_lcol = '0;
                        n_lrow = r_lrow + RW'(1);
                    end else begin
                        n_lcol = r_lcol + RW'(1);
                    end
                end
                if (cfg_wr) begin
                    n_lrow = '0;
                    n_lcol = '0;
                end
            end
            idu_pkg::S_ENTER: begin
                if (r_lvl == SW'(2)) begin
                    n_state = idu_pkg::S_B_RD0;
                end else begin
                    n_acc[r_lvl]  = '0;
                    n_sign[r_lvl] = 1'b0;
                    n_row[r_lvl]  = bp0.idx;
                    n_state       = idu_pkg::S_E_RD;
                end
            end
            idu_pkg::S_B_RD0: begin
                n_state = idu_pkg::S_B_RD1;
            end
            idu_pkg::S_B_RD1: begin
                n_opa   = rdata;
                n_state = idu_pkg::S_B_MUL0;
            end
            idu_pkg::S_B_MUL0: begin
                alu_req.op = idu_pkg::ALU_MUL;
                alu_req.a  = r_opa;
                alu_req.b  = rdata;
                n_p0       = alu_rsp.res;
                n_ov       = r_ov | alu_rsp.ov;
                n_state    = idu_pkg::S_B_RD3;
            end
            idu_pkg::S_B_RD3: begin
                n_opa   = rdata;
                n_state = idu_pkg::S_B_MUL1;
            end
            idu_pkg::S_B_MUL1: begin
                alu_req.op = idu_pkg::ALU_MUL;
                alu_req.a  = r_opa;
                alu_req.b  = rdata;
                n_ret      = alu_rsp.res;
                n_ov       = r_ov | alu_rsp.ov;
                n_state    = idu_pkg::S_B_SUB;
            end
            idu_pkg::S_B_SUB: begin
                alu_req.op = idu_pkg::ALU_SUB;
                alu_req.a  = r_p0;
                alu_req.b  = r_ret;
                n_ret      = alu_rsp.res;
                n_ov       = r_ov | alu_rsp.ov;
                n_state    = idu_pkg::S_POP;
            end
            idu_pkg::S_E_RD: begin
                n_state = idu_pkg::S_E_SIGN;
            end
            idu_pkg::S_E_SIGN: begin
                alu_req.op = r_sign[r_lvl] ? idu_pkg::ALU_SUB : idu_pkg::ALU_ADD;
                alu_req.a  = '0;
                alu_req.b  = rdata;
                n_t[r_lvl] = alu_rsp.res;
                n_ov       = r_ov | alu_rsp.ov;
                n_mask[r_lvl - SW'(1)] = r_mask[r_lvl] & ~(MS'(1) << r_row[r_lvl]);
                n_lvl      = r_lvl - SW'(1);
                n_state    = idu_pkg::S_ENTER;
            end
            idu_pkg::S_RET_MUL: begin
                alu_req.op = idu_pkg::ALU_MUL;
                alu_req.a  = r_t[r_lvl];
                alu_req.b  = r_ret;
                n_t[r_lvl] = alu_rsp.res;
                n_ov       = r_ov | alu_rsp.ov;
                n_state    = idu_pkg::S_RET_ADD;
            end
            idu_pkg::S_RET_ADD: begin
                alu_req.op   = idu_pkg::ALU_ADD;
                alu_req.a    = r_acc[r_lvl];
                alu_req.b    = r_t[r_lvl];
                n_acc[r_lvl] = alu_rsp.res;
                n_ov         = r_ov | alu_rsp.ov;
                n_state      = idu_pkg::S_RET_NEXT;
            end
            idu_pkg::S_RET_NEXT: begin
                n_sign[r_lvl] = !r_sign[r_lvl];
                if (nxt.found) begin
                    n_row[r_lvl] = nxt.idx;
                    n_state      = idu_pkg::S_E_RD;
                end else begin
                    n_ret   = r_acc[r_lvl];
                    n_state = idu_pkg::S_POP;
                end
            end
            idu_pkg::S_POP: begin
                if (r_lvl == size_use) begin
                    n_det       = r_ret;
                    n_det_ov    = r_ov;
                    n_out_valid = 1'b1;
                    n_state     = idu_pkg::S_LOAD;
                end else begin
                    n_lvl   = r_lvl + SW'(1);
                    n_state = idu_pkg::S_RET_MUL;
                end
            end
            default: begin
                n_state = idu_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= idu_pkg::S_LOAD;
            r_cfg       <= idu_pkg::SIZE_RESET;
            r_lrow      <= '0;
            r_lcol      <= '0;
            r_out_valid <= 1'b0;
            r_ov        <= 1'b0;
            r_lvl       <= '0;
        end else begin
            r_state     <= n_state;
            r_lrow      <= n_lrow;
            r_lcol      <= n_lcol;
            r_out_valid <= n_out_valid;
            r_ov        <= n_ov;
            r_lvl       <= n_lvl;
            if (cfg_wr) begin
                r_cfg <= i_pwdata[idu_pkg::CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask   <= n_mask;
        r_row    <= n_row;
        r_sign   <= n_sign;
        r_acc    <= n_acc;
        r_t      <= n_t;
        r_opa    <= n_opa;
        r_p0     <= n_p0;
        r_ret    <= n_ret;
        r_det    <= n_det;
        r_det_ov <= n_det_ov;
    end
endmodule
